// File: hdl/pge_pkg.sv
// Shared types and constants of the palette grid encoder.
package pge_pkg;

    localparam int GRID_POS = 64;
    localparam int POS_W    = 6;

    localparam logic [1:0] KIND_HDR   = 2'd0;
    localparam logic [1:0] KIND_PAL   = 2'd1;
    localparam logic [1:0] KIND_PLANE = 2'd2;
    localparam logic [1:0] KIND_RAW   = 2'd3;

    localparam logic [2:0] FMT_UNIFORM = 3'd0;
    localparam logic [2:0] FMT_RAW     = 3'd5;

    localparam logic [15:0] PAD_VALUE = 16'hFFFF;

    typedef struct packed {
        logic [15:0] block_value;
        logic [15:0] submerged_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  word_kind;
        logic [2:0]  format_code;
        logic [63:0] data_word;
        logic        last_word;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_CMP,
        S_PRE,
        S_HDR,
        S_PAL_RD,
        S_PAL_OUT,
        S_PLANE,
        S_RAW_IDX,
        S_RAW_PAL,
        S_RAW_ACC
    } t_state;

endpackage

// File: hdl/palette_grid_encoder.sv
// Palette grid encoder top level: palette build, index store and output sequencer.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------
//  item    | in        | start & !busy    | i_item  (pge_pkg::t_in_item)
//  result  | out       | o_strobe, 1 cyc  | o_result (pge_pkg::t_out_item)
//
// A lookup reads palette entries in turn (S_LOOK), comparing each (S_CMP) up to a match
// or a new value. An item is accepted in S_IDLE, then takes the block lookup, and a second
// lookup when the submerged value is non-zero. The 64th item adds a set-up state (S_PRE)
// and a burst: the header, then for a palette its words and the planes, one plane per
// cycle, or raw words built from an index read and a palette read per value.
// Reset is synchronous and clears the sequencer, palette count and position counter;
// the receiver takes every result beat as it appears.
module palette_grid_encoder #(
    parameter int PALETTE_SLOTS  = 128,
    parameter int MAX_INDEX_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  pge_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output pge_pkg::t_out_item o_result
);

    localparam int CNT_W    = $clog2(PALETTE_SLOTS + 1);
    localparam int ADDR_W   = $clog2(PALETTE_SLOTS);
    localparam int BITS_W   = $clog2(MAX_INDEX_BITS + 1);
    localparam int SLOT_W   = MAX_INDEX_BITS + 1;
    localparam int PAL_MAX  = 1 << MAX_INDEX_BITS;

    pge_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [pge_pkg::POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0]          r_scan, n_scan;
    logic                      r_phase, n_phase;
    logic [15:0]               r_bv, n_bv;
    logic [15:0]               r_sv, n_sv;
    logic [63:0]               r_plane [MAX_INDEX_BITS];
    logic [63:0]               n_plane [MAX_INDEX_BITS];
    logic [BITS_W-1:0]         r_bits, n_bits;
    logic [BITS_W-1:0]         r_b, n_b;
    logic [SLOT_W-1:0]         r_slot, n_slot;
    logic [1:0]                r_j, n_j;
    logic [3:0]                r_w, n_w;
    logic [47:0]               r_word, n_word;
    logic                      r_strobe, n_strobe;
    pge_pkg::t_out_item        r_res, n_res;

    logic [ADDR_W-1:0] r_idx_mem [pge_pkg::GRID_POS];
    logic [ADDR_W-1:0] r_idx_rd;
    logic              idx_we;
    logic [pge_pkg::POS_W-1:0] idx_raddr;

    logic              pal_we;
    logic [ADDR_W-1:0] pal_waddr, pal_raddr;
    logic [15:0]       pal_wdata, pal_rd;

    logic [15:0]       cur_v;
    logic [ADDR_W-1:0] hit_idx;
    logic              resolve;
    logic [BITS_W-1:0] bits_need;
    logic [SLOT_W-1:0] slot_last;
    logic [63:0]       plane_sel;

    pge_pal_mem #(
        .DEPTH (PALETTE_SLOTS),
        .ADDR_W(ADDR_W)
    ) u_pal (
        .i_clk  (i_clk),
        .i_we   (pal_we),
        .i_waddr(pal_waddr),
        .i_wdata(pal_wdata),
        .i_raddr(pal_raddr),
        .o_rdata(pal_rd)
    );

    always_ff @(posedge i_clk) begin
        if (idx_we) begin
            r_idx_mem[r_pos] <= hit_idx;
        end
        r_idx_rd <= r_idx_mem[idx_raddr];
    end

    assign cur_v = r_phase ? r_sv : r_bv;

    always_comb begin
        bits_need = BITS_W'(1);
        for (int k = 2; k <= MAX_INDEX_BITS; k++) begin
            if (r_cnt > CNT_W'(1 << (k - 1))) begin
                bits_need = BITS_W'(k);
            end
        end
    end

    assign slot_last = (SLOT_W'(1) << r_bits) - SLOT_W'(1);

    always_comb begin
        plane_sel = r_plane[0];
        for (int k = 0; k < MAX_INDEX_BITS; k++) begin
            if (r_b == BITS_W'(k)) begin
                plane_sel = r_plane[k];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_scan   = r_scan;
        n_phase  = r_phase;
        n_bv     = r_bv;
        n_sv     = r_sv;
        n_plane  = r_plane;
        n_bits   = r_bits;
        n_b      = r_b;
        n_slot   = r_slot;
        n_j      = r_j;
        n_w      = r_w;
        n_word   = r_word;
        n_strobe = 1'b0;
        n_res    = '0;
        pal_we    = 1'b0;
        pal_waddr = r_cnt[ADDR_W-1:0];
        pal_wdata = cur_v;
        pal_raddr = r_scan[ADDR_W-1:0];
        idx_we    = 1'b0;
        idx_raddr = {r_w, r_j};
        hit_idx   = r_scan[ADDR_W-1:0];
        resolve   = 1'b0;

        unique case (r_state)
            pge_pkg::S_IDLE: begin
                if (start) begin
                    n_bv    = i_item.block_value;
                    n_sv    = i_item.submerged_value;
                    n_phase = 1'b0;
                    n_scan  = '0;
                    n_state = pge_pkg::S_LOOK;
                end
            end
            pge_pkg::S_LOOK: begin
                if (r_scan >= r_cnt) begin
                    resolve = 1'b1;
                    if (r_cnt < CNT_W'(PALETTE_SLOTS)) begin
                        pal_we  = 1'b1;
                        hit_idx = r_cnt[ADDR_W-1:0];
                        n_cnt   = r_cnt + CNT_W'(1);
                    end else begin
                        hit_idx = ADDR_W'(PALETTE_SLOTS - 1);
                    end
                end else begin
                    n_state = pge_pkg::S_CMP;
                end
            end
            pge_pkg::S_CMP: begin
                if (pal_rd == cur_v) begin
                    resolve = 1'b1;
                end else begin
                    n_scan  = r_scan + CNT_W'(1);
                    n_state = pge_pkg::S_LOOK;
                end
            end
            pge_pkg::S_PRE: begin
                pal_raddr = '0;
                n_state   = pge_pkg::S_HDR;
            end
            pge_pkg::S_HDR: begin
                n_strobe = 1'b1;
                n_res.word_kind = pge_pkg::KIND_HDR;
                if (r_cnt <= CNT_W'(1)) begin
                    n_res.format_code = pge_pkg::FMT_UNIFORM;
                    n_res.data_word   = {48'd0, pal_rd};
                    n_res.last_word   = 1'b1;
                    n_cnt   = '0;
                    n_state = pge_pkg::S_IDLE;
                end else if (r_cnt <= CNT_W'(PAL_MAX)) begin
                    n_res.format_code = 3'(bits_need);
                    n_bits  = bits_need;
                    n_slot  = '0;
                    n_state = pge_pkg::S_PAL_RD;
                end else begin
                    n_res.format_code = pge_pkg::FMT_RAW;
                    n_w     = '0;
                    n_j     = '0;
                    n_state = pge_pkg::S_RAW_IDX;
                end
            end
            pge_pkg::S_PAL_RD: begin
                pal_raddr = ADDR_W'(r_slot);
                n_state   = pge_pkg::S_PAL_OUT;
            end
            pge_pkg::S_PAL_OUT: begin
                n_strobe = 1'b1;
                n_res.word_kind = pge_pkg::KIND_PAL;
                n_res.data_word = {48'd0,
                    (CNT_W'(r_slot) < r_cnt) ? pal_rd : pge_pkg::PAD_VALUE};
                if (r_slot == slot_last) begin
                    n_b     = '0;
                    n_state = pge_pkg::S_PLANE;
                end else begin
                    n_slot  = r_slot + SLOT_W'(1);
                    n_state = pge_pkg::S_PAL_RD;
                end
            end
            pge_pkg::S_PLANE: begin
                n_strobe = 1'b1;
                n_res.word_kind = pge_pkg::KIND_PLANE;
                n_res.data_word = plane_sel;
                if (r_b == r_bits - BITS_W'(1)) begin
                    n_res.last_word = 1'b1;
                    n_cnt   = '0;
                    n_state = pge_pkg::S_IDLE;
                end else begin
                    n_b = r_b + BITS_W'(1);
                end
            end
            pge_pkg::S_RAW_IDX: begin
                n_state = pge_pkg::S_RAW_PAL;
            end
            pge_pkg::S_RAW_PAL: begin
                pal_raddr = r_idx_rd;
                n_state   = pge_pkg::S_RAW_ACC;
            end
            pge_pkg::S_RAW_ACC: begin
                if (r_j == 2'd3) begin
                    n_strobe = 1'b1;
                    n_res.word_kind = pge_pkg::KIND_RAW;
                    n_res.data_word = {pal_rd, r_word};
                    if (r_w == 4'd15) begin
                        n_res.last_word = 1'b1;
                        n_cnt   = '0;
                        n_state = pge_pkg::S_IDLE;
                    end else begin
                        n_w     = r_w + 4'd1;
                        n_j     = '0;
                        n_state = pge_pkg::S_RAW_IDX;
                    end
                end else begin
                    n_word[16*r_j +: 16] = pal_rd;
                    n_j     = r_j + 2'd1;
                    n_state = pge_pkg::S_RAW_IDX;
                end
            end
            default: begin
                n_state = pge_pkg::S_IDLE;
            end
        endcase

        if (resolve) begin
            if (!r_phase) begin
                idx_we = 1'b1;
                for (int k = 0; k < MAX_INDEX_BITS; k++) begin
                    n_plane[k][~r_pos] = hit_idx[k];
                end
            end
            if (!r_phase && r_sv != 16'd0) begin
                n_phase = 1'b1;
                n_scan  = '0;
                n_state = pge_pkg::S_LOOK;
            end else if (r_pos == pge_pkg::POS_W'(pge_pkg::GRID_POS - 1)) begin
                n_pos   = '0;
                n_state = pge_pkg::S_PRE;
            end else begin
                n_pos   = r_pos + pge_pkg::POS_W'(1);
                n_state = pge_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pge_pkg::S_IDLE;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_phase <= n_phase;
        r_bv    <= n_bv;
        r_sv    <= n_sv;
        r_plane <= n_plane;
        r_bits  <= n_bits;
        r_b     <= n_b;
        r_slot  <= n_slot;
        r_j     <= n_j;
        r_w     <= n_w;
        r_word  <= n_word;
        r_res   <= n_res;
    end

    assign busy     = (r_state != pge_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// File: hdl/pge_pal_mem.sv
// Palette value store: one write port, one registered read port.
module pge_pal_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [15:0]       o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pge_checker.sv
// Port-level checks of the palette grid encoder, bound to the top level.
module pge_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input pge_pkg::t_out_item o_result
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_fmt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.word_kind != pge_pkg::KIND_HDR |->
            o_result.format_code == 3'd0)
        else $error("format code set on a non-header beat");

    a_uniform_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.word_kind == pge_pkg::KIND_HDR &&
            o_result.format_code == pge_pkg::FMT_UNIFORM |-> o_result.last_word)
        else $error("uniform header not final");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy |-> o_result.last_word)
        else $error("non-final beat while idle");

endmodule

bind palette_grid_encoder pge_checker u_pge_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

// File: verif/pge_checker.sv
// Checker for the palette grid encoder: predicts the output burst of each grid and compares beats.
module pge_scoreboard #(
    parameter int PALETTE_SLOTS  = 128,
    parameter int MAX_INDEX_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  pge_pkg::t_in_item  i_item,
    input  logic               o_strobe,
    input  pge_pkg::t_out_item o_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [15:0]        pal_vals [PALETTE_SLOTS];
    int                 pal_cnt;
    logic [6:0]         pos_idx [pge_pkg::GRID_POS];
    int                 pos_cnt;
    pge_pkg::t_out_item burst_q [$];

    assign o_pending = burst_q.size();

    function automatic int lookup_or_insert(logic [15:0] v);
        for (int i = 0; i < pal_cnt; i++) begin
            if (pal_vals[i] == v) return i;
        end
        if (pal_cnt < PALETTE_SLOTS) begin
            pal_vals[pal_cnt] = v;
            pal_cnt++;
            return pal_cnt - 1;
        end
        return PALETTE_SLOTS - 1;
    endfunction

    function automatic pge_pkg::t_out_item mk_word(logic [1:0] k, logic [2:0] f,
                                                   logic [63:0] d, logic l);
        pge_pkg::t_out_item w;
        w.word_kind   = k;
        w.format_code = f;
        w.data_word   = d;
        w.last_word   = l;
        return w;
    endfunction

    function automatic void queue_word(pge_pkg::t_out_item w);
        burst_q.insert(burst_q.size(), w);
    endfunction

    task automatic encode_grid();
        int          bits;
        int          slots;
        logic [63:0] acc;
        if (pal_cnt <= 1) begin
            queue_word(mk_word(pge_pkg::KIND_HDR, pge_pkg::FMT_UNIFORM,
                64'(pal_vals[0]), 1'b1));
        end else if (pal_cnt <= (1 << MAX_INDEX_BITS)) begin
            bits = 1;
            while ((1 << bits) < pal_cnt) bits++;
            slots = 1 << bits;
            queue_word(mk_word(pge_pkg::KIND_HDR, 3'(bits), 64'd0, 1'b0));
            for (int i = 0; i < slots; i++) begin
                queue_word(mk_word(pge_pkg::KIND_PAL, pge_pkg::FMT_UNIFORM,
                    64'(i < pal_cnt ? pal_vals[i] : pge_pkg::PAD_VALUE), 1'b0));
            end
            for (int b = 0; b < bits; b++) begin
                acc = '0;
                for (int i = 0; i < pge_pkg::GRID_POS; i++) acc[63-i] = pos_idx[i][b];
                queue_word(mk_word(pge_pkg::KIND_PLANE, pge_pkg::FMT_UNIFORM, acc,
                    b == bits - 1));
            end
        end else begin
            queue_word(mk_word(pge_pkg::KIND_HDR, pge_pkg::FMT_RAW, 64'd0, 1'b0));
            for (int w = 0; w < pge_pkg::GRID_POS / 4; w++) begin
                acc = '0;
                for (int j = 0; j < 4; j++) acc[16*j +: 16] = pal_vals[pos_idx[4*w+j]];
                queue_word(mk_word(pge_pkg::KIND_RAW, pge_pkg::FMT_UNIFORM, acc,
                    w == pge_pkg::GRID_POS/4 - 1));
            end
        end
        pal_cnt = 0;
    endtask

    always @(posedge i_clk) begin
        pge_pkg::t_out_item want;
        if (!i_rst_n) begin
            pal_cnt = 0;
            pos_cnt = 0;
            o_fail_count <= 0;
        end else begin
            if (o_strobe) begin
                if (burst_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, o_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = burst_q.pop_front();
                    if (want !== o_result) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                pos_idx[pos_cnt] = 7'(lookup_or_insert(i_item.block_value));
                if (i_item.submerged_value != 0)
                    void'(lookup_or_insert(i_item.submerged_value));
                if (pos_cnt == pge_pkg::GRID_POS - 1) begin
                    pos_cnt = 0;
                    encode_grid();
                end else begin
                    pos_cnt++;
                end
            end
        end
    end
endmodule

// File: verif/tb.sv
// Testbench top for the palette grid encoder: stimulus, clock, reset and verdict.
module tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    pge_pkg::t_in_item  i_item = '0;
    logic               busy;
    logic               o_strobe;
    pge_pkg::t_out_item o_result;
    int                 fail_count;
    int                 pending;
    pge_pkg::t_in_item  grid [pge_pkg::GRID_POS];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    palette_grid_encoder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    pge_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    int burst_left = 0;

    // Hold each beat until accepted; drop start for the gap between bursts.
    task automatic send_beat(pge_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Build grid with a target count of distinct values drawn from a small pool.
    task automatic fill_grid(int ndist, int mode);
        logic [15:0] pool [20];
        for (int i = 0; i < 20; i++) pool[i] = 16'($urandom);
        for (int i = 0; i < ndist && i < 20; i++) pool[i] = 16'($urandom_range(1, 65535));
        for (int p = 0; p < pge_pkg::GRID_POS; p++) begin
            grid[p].block_value     = pool[(p < ndist) ? p : $urandom_range(0, ndist - 1)];
            grid[p].submerged_value = 16'd0;
            if (mode == 1 && $urandom_range(0, 7) == 0)
                grid[p].submerged_value = pool[$urandom_range(0, ndist - 1)];
            else if (mode == 2 && $urandom_range(0, 15) == 0)
                grid[p].submerged_value = 16'($urandom);
        end
    endtask

    task automatic send_grid();
        for (int p = 0; p < pge_pkg::GRID_POS; p++) send_beat(grid[p]);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Uniform zero, then extremes in two values.
        for (int p = 0; p < pge_pkg::GRID_POS; p++) grid[p] = '0;
        send_grid();
        for (int p = 0; p < pge_pkg::GRID_POS; p++)
            grid[p] = '{(p % 2) ? 16'hFFFF : 16'h0000, (p == 5) ? 16'hFFFF : 16'h0000};
        send_grid();
        // Uniform blocks but a distinct submerged value.
        for (int p = 0; p < pge_pkg::GRID_POS; p++)
            grid[p] = '{16'h1234, (p == 9) ? 16'hABCD : 16'h0};
        send_grid();
        // Small and large palettes, then raw.
        fill_grid($urandom_range(3, 8), $urandom_range(0, 2));
        send_grid();
        fill_grid($urandom_range(9, 16), $urandom_range(0, 2));
        send_grid();
        for (int p = 0; p < pge_pkg::GRID_POS; p++) grid[p] = 32'($urandom);
        send_grid();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
